@@ rtl/srtc_pkg.sv @@
`default_nettype none
package srtc_pkg;

  localparam int unsigned HalfPeriodW = 16;
  localparam int unsigned CmdW        = 8;
  localparam int unsigned FieldW      = 8;
  localparam int unsigned NumFields   = 7;
  localparam int unsigned CfgIndexW   = 1;
  localparam int unsigned CfgDataW    = 16;
  localparam int unsigned BitCountW   = 3;
  localparam int unsigned ByteCountW  = 3;

  localparam logic [HalfPeriodW-1:0] HalfPeriodReset = 16'd100;
  localparam logic [CmdW-1:0]        CommandReset    = 8'h65;

  localparam logic [BitCountW-1:0]  LastBit  = 3'd7;
  localparam logic [ByteCountW-1:0] LastByte = 3'd6;

  localparam logic [CfgIndexW-1:0] CfgHalfPeriod = 1'b0;
  localparam logic [CfgIndexW-1:0] CfgCommand    = 1'b1;

  // packed bcd byte to binary, low nibble plus ten times high nibble
  function automatic logic [FieldW-1:0] bcd_to_bin(input logic [FieldW-1:0] v);
    logic [FieldW-1:0] hi;
    logic [FieldW-1:0] lo;
    hi = {4'd0, v[7:4]};
    lo = {4'd0, v[3:0]};
    return lo + (hi << 3) + (hi << 1);
  endfunction

endpackage
`default_nettype wire

@@ rtl/serial_rtc_time_reader_top.sv @@
// an accepted request's result is on the output register in the next cycle
// throughput: one request per cycle; a request is taken whenever the output
//   register is empty or being taken in the same cycle
// reset (synchronous, active high): sequencer idle, pins low with data driven,
//   time fields zero, half period 100 and command byte 0x65
`default_nettype none
module serial_rtc_time_reader_top (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire  [srtc_pkg::CfgIndexW-1:0]       cfg_index,
  input  wire  [srtc_pkg::CfgDataW-1:0]        cfg_data,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire                                  start_req,
  input  wire                                  sio_in,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic                                 pin_sck,
  output logic                                 pin_sio,
  output logic                                 pin_cs,
  output logic                                 sio_drive,
  output logic                                 done_res,
  output logic [srtc_pkg::FieldW-1:0]          year_value,
  output logic [srtc_pkg::FieldW-1:0]          month_value,
  output logic [srtc_pkg::FieldW-1:0]          day_value,
  output logic [srtc_pkg::FieldW-1:0]          weekday_value,
  output logic [srtc_pkg::FieldW-1:0]          hour_value,
  output logic [srtc_pkg::FieldW-1:0]          minute_value,
  output logic [srtc_pkg::FieldW-1:0]          second_value
);

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_PRE     = 3'd1,
    PH_SEND_LO = 3'd2,
    PH_SEND_HI = 3'd3,
    PH_READ_LO = 3'd4,
    PH_READ_HI = 3'd5
  } phase_t;

  logic [srtc_pkg::HalfPeriodW-1:0] half_period;
  logic [srtc_pkg::CmdW-1:0]        command_byte;

  phase_t                            phase, phase_next;
  logic [srtc_pkg::HalfPeriodW-1:0]  wait_count, wait_count_next;
  logic [srtc_pkg::BitCountW-1:0]    bit_count, bit_count_next;
  logic [srtc_pkg::ByteCountW-1:0]   byte_count, byte_count_next;
  logic [srtc_pkg::FieldW-1:0]       shift_reg, shift_reg_next;
  logic [srtc_pkg::FieldW-1:0]       time_fields [srtc_pkg::NumFields];
  logic                              pin_sck_next, pin_sio_next, pin_cs_next;
  logic                              sio_drive_next, done_res_next;
  logic                              field_we;
  logic [srtc_pkg::FieldW-1:0]       field_value;
  logic [srtc_pkg::FieldW-1:0]       sampled;
  logic [srtc_pkg::HalfPeriodW-1:0]  reload;
  logic                              in_accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  assign reload  = (half_period == '0) ? '0 : half_period - 1'b1;
  assign sampled = shift_reg | (srtc_pkg::FieldW'(sio_in) << bit_count);
  assign field_value = srtc_pkg::bcd_to_bin(sampled);

  always_comb begin
    phase_next      = phase;
    wait_count_next = wait_count;
    bit_count_next  = bit_count;
    byte_count_next = byte_count;
    shift_reg_next  = shift_reg;
    pin_sck_next    = pin_sck;
    pin_sio_next    = pin_sio;
    pin_cs_next     = pin_cs;
    sio_drive_next  = sio_drive;
    done_res_next   = 1'b0;
    field_we        = 1'b0;

    case (phase)
      PH_PRE: begin
        phase_next      = PH_SEND_LO;
        wait_count_next = reload;
        pin_sck_next    = 1'b0;
        pin_sio_next    = shift_reg[7];
        pin_cs_next     = 1'b1;
        sio_drive_next  = 1'b1;
      end
      PH_SEND_LO, PH_SEND_HI, PH_READ_LO, PH_READ_HI: begin
        if (wait_count != '0) begin
          wait_count_next = wait_count - 1'b1;
        end else if (phase == PH_SEND_LO) begin
          phase_next      = PH_SEND_HI;
          wait_count_next = reload;
          pin_sck_next    = 1'b1;
        end else if (phase == PH_SEND_HI) begin
          wait_count_next = reload;
          if (bit_count == srtc_pkg::LastBit) begin
            phase_next     = PH_READ_LO;
            bit_count_next = '0;
            shift_reg_next = '0;
            pin_sck_next   = 1'b0;
            pin_sio_next   = 1'b0;
            pin_cs_next    = 1'b1;
            sio_drive_next = 1'b0;
          end else begin
            phase_next     = PH_SEND_LO;
            bit_count_next = bit_count + 1'b1;
            shift_reg_next = shift_reg << 1;
            pin_sck_next   = 1'b0;
            pin_sio_next   = shift_reg[6];
            pin_cs_next    = 1'b1;
            sio_drive_next = 1'b1;
          end
        end else if (phase == PH_READ_LO) begin
          phase_next      = PH_READ_HI;
          wait_count_next = reload;
          pin_sck_next    = 1'b1;
          pin_sio_next    = 1'b0;
          pin_cs_next     = 1'b1;
          sio_drive_next  = 1'b0;
        end else begin
          shift_reg_next  = sampled;
          phase_next      = PH_READ_LO;
          wait_count_next = reload;
          pin_sck_next    = 1'b0;
          pin_sio_next    = 1'b0;
          pin_cs_next     = 1'b1;
          sio_drive_next  = 1'b0;
          if (bit_count == srtc_pkg::LastBit) begin
            bit_count_next = '0;
            shift_reg_next = '0;
            field_we       = 1'b1;
            if (byte_count >= srtc_pkg::LastByte) begin
              byte_count_next = '0;
              phase_next      = PH_IDLE;
              wait_count_next = '0;
              pin_cs_next     = 1'b0;
              sio_drive_next  = 1'b1;
              done_res_next   = 1'b1;
            end else begin
              byte_count_next = byte_count + 1'b1;
            end
          end else begin
            bit_count_next = bit_count + 1'b1;
          end
        end
      end
      default: begin
        phase_next = PH_IDLE;
        if (start_req) begin
          phase_next      = PH_PRE;
          pin_sck_next    = 1'b1;
          pin_sio_next    = 1'b0;
          pin_cs_next     = 1'b1;
          sio_drive_next  = 1'b1;
          bit_count_next  = '0;
          byte_count_next = '0;
          shift_reg_next  = command_byte;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period  <= srtc_pkg::HalfPeriodReset;
      command_byte <= srtc_pkg::CommandReset;
      phase        <= PH_IDLE;
      wait_count   <= '0;
      bit_count    <= '0;
      byte_count   <= '0;
      shift_reg    <= '0;
      for (int i = 0; i < srtc_pkg::NumFields; i++) begin
        time_fields[i] <= '0;
      end
      pin_sck   <= 1'b0;
      pin_sio   <= 1'b0;
      pin_cs    <= 1'b0;
      sio_drive <= 1'b1;
      done_res  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          srtc_pkg::CfgHalfPeriod: half_period  <= cfg_data;
          srtc_pkg::CfgCommand:    command_byte <= cfg_data[srtc_pkg::CmdW-1:0];
          default: ;
        endcase
      end
      out_valid <= in_accept || (out_valid && !out_ready);
      if (in_accept) begin
        phase      <= phase_next;
        wait_count <= wait_count_next;
        bit_count  <= bit_count_next;
        byte_count <= byte_count_next;
        shift_reg  <= shift_reg_next;
        pin_sck    <= pin_sck_next;
        pin_sio    <= pin_sio_next;
        pin_cs     <= pin_cs_next;
        sio_drive  <= sio_drive_next;
        done_res   <= done_res_next;
        if (field_we && byte_count <= srtc_pkg::LastByte) begin
          time_fields[byte_count] <= field_value;
        end
      end
    end
  end

  assign year_value    = time_fields[0];
  assign month_value   = time_fields[1];
  assign day_value     = time_fields[2];
  assign weekday_value = time_fields[3];
  assign hour_value    = time_fields[4];
  assign minute_value  = time_fields[5];
  assign second_value  = time_fields[6];

endmodule
`default_nettype wire
